// ===== src/typed_field_stream_decoder_defines.svh =====
// Assertion macros shared by the typed field stream decoder RTL.
// Needs clk and arst_n in the scope of each use; define ASSERT_OFF to drop them.
`ifndef TYPED_FIELD_STREAM_DECODER_DEFINES_SVH
`define TYPED_FIELD_STREAM_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TFSD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tfsd assertion failed");
// next-cycle implication
`define TFSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tfsd assertion failed");
`else
`define TFSD_ASSERT_IMPL(label, ante, cons)
`define TFSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/tfsd_pkg.sv =====
// Package for the typed field stream decoder: type codes, event kinds, event struct.
// No dependencies.
package tfsd_pkg;

	localparam int MAX_DEPTH = 15;
	localparam logic [3:0] DEPTH_LIMIT = (MAX_DEPTH < 15) ? 4'(MAX_DEPTH) : 4'd15;

	// record type bytes
	localparam logic [7:0] T_INT32      = 8'd0;
	localparam logic [7:0] T_UINT32     = 8'd1;
	localparam logic [7:0] T_BOOL       = 8'd2;
	localparam logic [7:0] T_FLOAT      = 8'd3;
	localparam logic [7:0] T_STRING     = 8'd4;
	localparam logic [7:0] T_STRUCT     = 8'd5;
	localparam logic [7:0] T_STRUCT_END = 8'd6;

	// event kinds
	localparam logic [3:0] EV_HEADER   = 4'd0;
	localparam logic [3:0] EV_NAME     = 4'd1;
	localparam logic [3:0] EV_INT32    = 4'd2;
	localparam logic [3:0] EV_UINT32   = 4'd3;
	localparam logic [3:0] EV_BOOL     = 4'd4;
	localparam logic [3:0] EV_FLOAT    = 4'd5;
	localparam logic [3:0] EV_STR_LEN  = 4'd6;
	localparam logic [3:0] EV_STR_BYTE = 4'd7;
	localparam logic [3:0] EV_OPEN     = 4'd8;
	localparam logic [3:0] EV_CLOSE    = 4'd9;
	localparam logic [3:0] EV_UNKNOWN  = 4'd10;
	localparam logic [3:0] EV_OVERFLOW = 4'd11;
	localparam logic [3:0] EV_STRAY    = 4'd12;

	typedef struct packed {
		logic               valid;
		logic [3:0]         kind;
		logic [7:0]         rtype;
		logic [31:0]        raw;
		logic signed [7:0]  fexp;
		logic signed [23:0] fman;
		logic [3:0]         depth;
		logic               fin;
	} event_t;

endpackage

// ===== src/tfsd_core.sv =====
// Parse state machine of the typed field stream decoder: one byte per commit.
// Depends on tfsd_pkg and typed_field_stream_decoder_defines.svh.
`include "typed_field_stream_decoder_defines.svh"
module tfsd_core import tfsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       active,   // a byte is presented
	input  logic       commit,   // the byte is consumed this cycle
	input  logic [7:0] byte_in,
	output event_t     evt
);

	typedef enum logic [2:0] {
		PH_TYPE, PH_NLEN, PH_NAME, PH_WORD, PH_BOOL, PH_SLEN, PH_STR
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  pos_q, pos_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] aw_q, aw_d;
	logic [7:0]  type_q, type_d;
	logic [3:0]  depth_q, depth_d;
	logic        halted_q, halted_d;

	// end-of-name decision
	phase_t      fn_phase;
	logic        fn_evt;
	logic [3:0]  fn_kind;
	logic [3:0]  fn_depth;
	logic        fn_halt;

	logic [31:0] shifted;
	logic [31:0] rem_dec;

	assign shifted = {aw_q[23:0], byte_in};
	assign rem_dec = rem_q - 32'd1;

	always_comb begin
		fn_phase = PH_TYPE;
		fn_evt   = 1'b0;
		fn_kind  = EV_NAME;
		fn_depth = depth_q;
		fn_halt  = 1'b0;
		case (type_q)
			T_INT32, T_UINT32, T_FLOAT: fn_phase = PH_WORD;
			T_BOOL:   fn_phase = PH_BOOL;
			T_STRING: fn_phase = PH_SLEN;
			T_STRUCT: begin
				fn_evt = 1'b1;
				if (depth_q >= DEPTH_LIMIT) begin
					fn_halt = 1'b1;
					fn_kind = EV_OVERFLOW;
				end else begin
					fn_depth = depth_q + 4'd1;
					fn_kind  = EV_OPEN;
				end
			end
			default: begin
				// unknown type leaves the current level; at depth zero it halts the parser
				fn_evt  = 1'b1;
				fn_kind = EV_UNKNOWN;
				if (depth_q == 4'd0) fn_halt = 1'b1;
				else fn_depth = depth_q - 4'd1;
			end
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		rem_d    = rem_q;
		aw_d     = aw_q;
		type_d   = type_q;
		depth_d  = depth_q;
		halted_d = halted_q;
		evt      = '0;
		if (active && !halted_q) begin
			case (phase_q)
				PH_TYPE: begin
					type_d    = byte_in;
					evt.valid = 1'b1;
					if (byte_in == T_STRUCT_END) begin
						if (depth_q == 4'd0) begin
							halted_d = 1'b1;
							evt.kind = EV_STRAY;
						end else begin
							depth_d  = depth_q - 4'd1;
							evt.kind = EV_CLOSE;
						end
					end else begin
						phase_d  = PH_NLEN;
						pos_d    = 2'd0;
						evt.kind = EV_HEADER;
					end
				end
				PH_NLEN: begin
					aw_d = shifted;
					if (pos_q != 2'd3) begin
						pos_d = pos_q + 2'd1;
					end else begin
						pos_d = 2'd0;
						rem_d = shifted;
						if (shifted != 32'd0) begin
							phase_d = PH_NAME;
						end else begin
							// empty name: finish right here
							phase_d   = fn_phase;
							depth_d   = fn_depth;
							halted_d  = fn_halt;
							evt.valid = fn_evt;
							evt.kind  = fn_kind;
						end
					end
				end
				PH_NAME: begin
					rem_d     = rem_dec;
					evt.valid = 1'b1;
					evt.raw   = {24'd0, byte_in};
					evt.kind  = EV_NAME;
					if (rem_dec == 32'd0) begin
						pos_d    = 2'd0;
						phase_d  = fn_phase;
						depth_d  = fn_depth;
						halted_d = fn_halt;
						evt.fin  = 1'b1;
						if (fn_evt) evt.kind = fn_kind;
					end
				end
				PH_WORD: begin
					aw_d = shifted;
					if (pos_q != 2'd3) begin
						pos_d = pos_q + 2'd1;
					end else begin
						pos_d     = 2'd0;
						phase_d   = PH_TYPE;
						evt.valid = 1'b1;
						evt.raw   = shifted;
						if (type_q == T_FLOAT) begin
							evt.kind = EV_FLOAT;
							evt.fexp = signed'(shifted[31:24]);
							evt.fman = signed'(shifted[23:0]);
						end else if (type_q == T_INT32) begin
							evt.kind = EV_INT32;
						end else begin
							evt.kind = EV_UINT32;
						end
					end
				end
				PH_BOOL: begin
					phase_d   = PH_TYPE;
					evt.valid = 1'b1;
					evt.kind  = EV_BOOL;
					evt.raw   = {24'd0, byte_in};
				end
				PH_SLEN: begin
					aw_d = shifted;
					if (pos_q != 2'd3) begin
						pos_d = pos_q + 2'd1;
					end else begin
						pos_d     = 2'd0;
						rem_d     = shifted;
						phase_d   = (shifted != 32'd0) ? PH_STR : PH_TYPE;
						evt.valid = 1'b1;
						evt.kind  = EV_STR_LEN;
						evt.raw   = shifted;
					end
				end
				PH_STR: begin
					rem_d     = rem_dec;
					evt.valid = 1'b1;
					evt.kind  = EV_STR_BYTE;
					evt.raw   = {24'd0, byte_in};
					if (rem_dec == 32'd0) begin
						phase_d = PH_TYPE;
						evt.fin = 1'b1;
					end
				end
				default: phase_d = PH_TYPE;
			endcase
		end
		evt.rtype = type_d;
		evt.depth = depth_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			pos_q    <= 2'd0;
			rem_q    <= 32'd0;
			aw_q     <= 32'd0;
			type_q   <= 8'd0;
			depth_q  <= 4'd0;
			halted_q <= 1'b0;
		end else if (commit) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			rem_q    <= rem_d;
			aw_q     <= aw_d;
			type_q   <= type_d;
			depth_q  <= depth_d;
			halted_q <= halted_d;
		end
	end

	`TFSD_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q)
	`TFSD_ASSERT_IMPL(a_depth_limit, 1'b1, depth_q <= DEPTH_LIMIT)
	`TFSD_ASSERT_IMPL(a_quiet_halted, halted_q, !evt.valid)
	`TFSD_ASSERT_NEXT(a_stray_halts, commit && evt.valid && evt.kind == EV_STRAY, halted_q)

endmodule

// ===== src/typed_field_stream_decoder.sv =====
// Top level of the typed field stream decoder: input register, parser, result register.
// Depends on tfsd_pkg, tfsd_core and typed_field_stream_decoder_defines.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / stream_byte) takes one stream byte per
//   transaction. Output channel (out_valid / out_stall / event fields) delivers
//   one parse event per transaction. A byte produces zero or one event.
// Path: an accepted byte is held in the input register; its event (if any) is
//   then registered in the result register and shown on out_valid.
// Throughput: one byte per cycle, sustained, as long as the receiver does not
//   stall. The parse state update is a single pass through tfsd_core.
// Stall: while a result waits under out_stall, bytes are still taken into the
//   input register. Each is parsed at once if it makes no event; the first one
//   that makes an event holds there and in_stall rises until the result is taken.
// Reset: arst_n clears both registers' valid flags and the parser state
//   (expect type byte, depth zero, not halted). After a stray close, a struct
//   overflow or an unknown type at depth zero, bytes are still accepted but
//   dropped until the next reset.
`include "typed_field_stream_decoder_defines.svh"
module typed_field_stream_decoder import tfsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         stream_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         event_kind,
	output logic [7:0]         record_type,
	output logic [31:0]        raw_value,
	output logic signed [7:0]  float_exponent,
	output logic signed [23:0] float_mantissa,
	output logic [3:0]         nesting_depth,
	output logic               final_byte
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic               out_valid_q;
	logic [3:0]         event_kind_q;
	logic [7:0]         record_type_q;
	logic [31:0]        raw_value_q;
	logic signed [7:0]  float_exponent_q;
	logic signed [23:0] float_mantissa_q;
	logic [3:0]         nesting_depth_q;
	logic               final_byte_q;

	event_t evt;
	logic   s1_go;

	tfsd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.active  (valid_s1),
		.commit  (s1_go),
		.byte_in (byte_s1),
		.evt     (evt)
	);

	// byte in s1 moves on unless it has an event and the result slot is blocked
	assign s1_go    = valid_s1 && (!out_valid_q || !out_stall || !evt.valid);
	assign in_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= stream_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && evt.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && evt.valid) begin
			event_kind_q     <= evt.kind;
			record_type_q    <= evt.rtype;
			raw_value_q      <= evt.raw;
			float_exponent_q <= evt.fexp;
			float_mantissa_q <= evt.fman;
			nesting_depth_q  <= evt.depth;
			final_byte_q     <= evt.fin;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_kind     = event_kind_q;
	assign record_type    = record_type_q;
	assign raw_value      = raw_value_q;
	assign float_exponent = float_exponent_q;
	assign float_mantissa = float_mantissa_q;
	assign nesting_depth  = nesting_depth_q;
	assign final_byte     = final_byte_q;

	`TFSD_ASSERT_IMPL(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall && evt.valid)
	`TFSD_ASSERT_NEXT(a_s1_hold, in_stall, valid_s1 && $stable(byte_s1))
	`TFSD_ASSERT_NEXT(a_result_hold, out_valid_q && out_stall, out_valid_q && $stable(raw_value_q))

endmodule

// ===== bench/tb_typed_field_stream_decoder.sv =====
// Self-checking bench for typed_field_stream_decoder: directed and random record streams.
// Depends on tfsd_pkg and the decoder RTL; a scoreboard class predicts every parse event.
`timescale 1ns / 100ps
module tb_typed_field_stream_decoder;
	import tfsd_pkg::*;

	// Run limit in clock cycles, far above the slowest legal run
	localparam int CYCLE_LIMIT = 400000;
	// Cycles to watch for stray events once nothing is outstanding
	localparam int DRAIN_CYCLES = 12;

	// One parse event as seen on the result channel
	typedef struct packed {
		logic [3:0]         kind;
		logic [7:0]         rtype;
		logic [31:0]        raw;
		logic signed [7:0]  fexp;
		logic signed [23:0] fman;
		logic [3:0]         depth;
		logic               fin;
	} parse_event_t;

	// Where the parser stands within a record
	typedef enum logic [2:0] {
		AWAIT_TYPE,
		NAME_LEN,
		NAME_BYTES,
		WORD_BYTES,
		BOOL_BYTE,
		STR_LEN,
		STR_BYTES
	} parse_phase_e;

	// How the run is brought to its terminal (halted) state
	typedef enum int {
		HALT_STRAY,
		HALT_UNKNOWN,
		HALT_OVERFLOW
	} halt_kind_e;

	// Scoreboard: mirrors the parser state and holds the events still owed by the block.
	class decode_scoreboard;
		parse_phase_e phase;
		logic [1:0]   pos;
		logic [31:0]  remaining;
		logic [31:0]  word;
		logic [7:0]   cur_type;
		logic [3:0]   depth;
		bit           halted;
		parse_event_t pending[$];
		int           errors;

		function new();
			phase = AWAIT_TYPE;
			pos = 2'd0;
			remaining = 32'd0;
			word = 32'd0;
			cur_type = 8'd0;
			depth = 4'd0;
			halted = 1'b0;
			errors = 0;
		endfunction

		function parse_event_t make_event(logic [3:0] kind, logic [31:0] raw, logic fin);
			parse_event_t e;
			e.kind = kind;
			e.rtype = cur_type;
			e.raw = raw;
			e.fexp = '0;
			e.fman = '0;
			e.depth = depth;
			e.fin = fin;
			return e;
		endfunction

		function void push_event(logic [3:0] kind, logic [31:0] raw, logic fin);
			pending.push_back(make_event(kind, raw, fin));
		endfunction

		// Name done: pick the value phase, or finish a struct / unknown record.
		// Returns the event kind, or -1 when the record goes on silently.
		function int close_name();
			pos = 2'd0;
			case (cur_type)
				T_INT32, T_UINT32, T_FLOAT: begin
					phase = WORD_BYTES;
					return -1;
				end
				T_BOOL: begin
					phase = BOOL_BYTE;
					return -1;
				end
				T_STRING: begin
					phase = STR_LEN;
					return -1;
				end
				T_STRUCT: begin
					phase = AWAIT_TYPE;
					if (depth >= DEPTH_LIMIT) begin
						halted = 1'b1;
						return EV_OVERFLOW;
					end
					depth++;
					return EV_OPEN;
				end
				default: begin
					// unknown type leaves the current level; at top level the stream ends
					phase = AWAIT_TYPE;
					if (depth == 0)
						halted = 1'b1;
					else
						depth--;
					return EV_UNKNOWN;
				end
			endcase
		endfunction

		// Accepted input transaction: advance the mirror and queue any event it causes
		function void note_byte(logic [7:0] b);
			int k;
			parse_event_t e;
			if (halted)
				return;
			case (phase)
				AWAIT_TYPE: begin
					cur_type = b;
					if (b == T_STRUCT_END) begin
						if (depth == 0) begin
							halted = 1'b1;
							push_event(EV_STRAY, 32'd0, 1'b0);
						end else begin
							depth--;
							push_event(EV_CLOSE, 32'd0, 1'b0);
						end
					end else begin
						phase = NAME_LEN;
						pos = 2'd0;
						push_event(EV_HEADER, 32'd0, 1'b0);
					end
				end
				NAME_LEN: begin
					word = {word[23:0], b};
					if (pos < 3) begin
						pos++;
					end else begin
						pos = 2'd0;
						remaining = word;
						if (remaining != 0) begin
							phase = NAME_BYTES;
						end else begin
							k = close_name();
							if (k >= 0)
								push_event(k[3:0], 32'd0, 1'b0);
						end
					end
				end
				NAME_BYTES: begin
					remaining--;
					if (remaining != 0) begin
						push_event(EV_NAME, {24'd0, b}, 1'b0);
					end else begin
						k = close_name();
						push_event((k < 0) ? EV_NAME : k[3:0], {24'd0, b}, 1'b1);
					end
				end
				WORD_BYTES: begin
					word = {word[23:0], b};
					if (pos < 3) begin
						pos++;
					end else begin
						pos = 2'd0;
						phase = AWAIT_TYPE;
						if (cur_type == T_FLOAT) begin
							e = make_event(EV_FLOAT, word, 1'b0);
							e.fexp = signed'(word[31:24]);
							e.fman = signed'(word[23:0]);
							pending.push_back(e);
						end else begin
							push_event((cur_type == T_INT32) ? EV_INT32 : EV_UINT32, word, 1'b0);
						end
					end
				end
				BOOL_BYTE: begin
					phase = AWAIT_TYPE;
					push_event(EV_BOOL, {24'd0, b}, 1'b0);
				end
				STR_LEN: begin
					word = {word[23:0], b};
					if (pos < 3) begin
						pos++;
					end else begin
						pos = 2'd0;
						remaining = word;
						// an empty string ends the record at its length
						phase = (remaining != 0) ? STR_BYTES : AWAIT_TYPE;
						push_event(EV_STR_LEN, word, 1'b0);
					end
				end
				STR_BYTES: begin
					remaining--;
					if (remaining == 0) begin
						phase = AWAIT_TYPE;
						push_event(EV_STR_BYTE, {24'd0, b}, 1'b1);
					end else begin
						push_event(EV_STR_BYTE, {24'd0, b}, 1'b0);
					end
				end
				default: phase = AWAIT_TYPE;
			endcase
		endfunction

		function void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			end
		endfunction

		// Accepted output transaction: compare with the oldest owed event
		function void check_event(parse_event_t got);
			parse_event_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected event, expected none, got kind %0d raw %h",
					$time, got.kind, got.raw);
				return;
			end
			want = pending.pop_front();
			field_check("event_kind", 32'(want.kind), 32'(got.kind));
			field_check("record_type", 32'(want.rtype), 32'(got.rtype));
			field_check("raw_value", want.raw, got.raw);
			field_check("float_exponent", 32'(want.fexp), 32'(got.fexp));
			field_check("float_mantissa", 32'(want.fman), 32'(got.fman));
			field_check("nesting_depth", 32'(want.depth), 32'(got.depth));
			field_check("final_byte", 32'(want.fin), 32'(got.fin));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         stream_byte;
	logic               out_valid;
	logic               out_stall;
	logic [3:0]         event_kind;
	logic [7:0]         record_type;
	logic [31:0]        raw_value;
	logic signed [7:0]  float_exponent;
	logic signed [23:0] float_mantissa;
	logic [3:0]         nesting_depth;
	logic               final_byte;

	decode_scoreboard sb = new();

	int send_idle_pct;   // chance per cycle that the sender holds off
	int recv_stall_pct;  // chance per cycle that the receiver stalls
	int gen_depth;       // struct depth of the stream generated so far
	int bytes_sent;
	int cycles;

	typed_field_stream_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.stream_byte   (stream_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.record_type   (record_type),
		.raw_value     (raw_value),
		.float_exponent(float_exponent),
		.float_mantissa(float_mantissa),
		.nesting_depth (nesting_depth),
		.final_byte    (final_byte)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Sampling in the active region of the edge sees pre-edge values of both sides,
	// so a transaction is counted exactly when the block counts it.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_byte(stream_byte);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_event({event_kind, record_type, raw_value, float_exponent,
				float_mantissa, nesting_depth, final_byte});
	end

	// Receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		else
			out_stall <= 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[typed_field_stream_decoder] ERROR");
			$finish;
		end
	end

	// One input transaction: optional random gap, then hold the byte until taken.
	// Returns in the time step of acceptance, so the next call's single
	// nonblocking write decides whether valid stays high.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Big-endian 32-bit field
	task automatic send_word(input logic [31:0] w);
		send_byte(w[31:24]);
		send_byte(w[23:16]);
		send_byte(w[15:8]);
		send_byte(w[7:0]);
	endtask

	// Whole record: type, name length, name, then the value its type calls for.
	// Struct and unknown records move the generator's depth like the parser does.
	task automatic send_record(input logic [7:0] rtype, input int name_len,
			input logic [31:0] value, input int str_len);
		send_byte(rtype);
		send_word(name_len);
		repeat (name_len)
			send_byte(8'($urandom));
		case (rtype)
			T_INT32, T_UINT32, T_FLOAT: send_word(value);
			T_BOOL: send_byte(value[7:0]);
			T_STRING: begin
				send_word(str_len);
				repeat (str_len)
					send_byte(8'($urandom));
			end
			T_STRUCT: gen_depth++;
			default: if (gen_depth > 0) gen_depth--;
		endcase
	endtask

	task automatic send_close();
		send_byte(T_STRUCT_END);
		if (gen_depth > 0)
			gen_depth--;
	endtask

	// Mostly short lengths, now and then a longer one
	function automatic int len_pick(int short_max, int long_max);
		return ($urandom_range(7) == 0) ? $urandom_range(long_max, short_max + 1)
			: $urandom_range(short_max);
	endfunction

	// Well-formed records with random content. Unknown types and closes only
	// appear inside a struct and opens stop below the depth limit, so the
	// parser never halts here.
	task automatic random_records(input int n_bytes);
		int stop_at;
		int pick;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (gen_depth > 0 && pick < 6)
				send_record(8'($urandom_range(255, 7)), len_pick(3, 12), 0, 0);
			else if (gen_depth < DEPTH_LIMIT && pick < 18)
				send_record(T_STRUCT, len_pick(3, 12), 0, 0);
			else if (gen_depth > 0 && pick < 30)
				send_close();
			else
				send_record(8'($urandom_range(4)), len_pick(3, 12), $urandom, len_pick(4, 24));
		end
	endtask

	task automatic directed_records();
		// value extremes of every scalar type, empty and non-empty names
		send_record(T_INT32, 0, 32'h8000_0000, 0);
		send_record(T_INT32, 1, 32'h7fff_ffff, 0);
		send_record(T_UINT32, 2, 32'hffff_ffff, 0);
		send_record(T_UINT32, 0, 32'h0000_0000, 0);
		send_record(T_BOOL, 1, 32'h00, 0);
		send_record(T_BOOL, 0, 32'hff, 0);
		// float: most negative exponent/mantissa, then most positive
		send_record(T_FLOAT, 1, 32'h8080_0000, 0);
		send_record(T_FLOAT, 0, 32'h7f7f_ffff, 0);
		// empty string closes at its length, then a short one
		send_record(T_STRING, 1, 0, 0);
		send_record(T_STRING, 0, 0, 3);
		// struct with empty name, struct with a name
		send_record(T_STRUCT, 0, 0, 0);
		send_record(T_STRUCT, 2, 0, 0);
		// unknown types inside structs leave one level each
		send_record(8'd7, 0, 0, 0);
		send_record(8'hff, 3, 0, 0);
		// nest to the depth limit, one record at the bottom, unwind with closes
		while (gen_depth < DEPTH_LIMIT)
			send_record(T_STRUCT, 0, 0, 0);
		send_record(T_INT32, 1, $urandom, 0);
		while (gen_depth > 0)
			send_close();
	endtask

	// Drive the parser into its terminal state, then show it ignores further bytes
	task automatic halting_tail();
		halt_kind_e how;
		how = halt_kind_e'($urandom_range(2));
		case (how)
			HALT_STRAY: begin
				while (gen_depth > 0)
					send_close();
				send_byte(T_STRUCT_END);
			end
			HALT_UNKNOWN: begin
				while (gen_depth > 0)
					send_close();
				send_record(8'($urandom_range(255, 7)), len_pick(2, 6), 0, 0);
			end
			default: begin
				while (gen_depth < DEPTH_LIMIT)
					send_record(T_STRUCT, len_pick(2, 6), 0, 0);
				send_record(T_STRUCT, 1, 0, 0);
			end
		endcase
		repeat (16)
			send_byte(8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		stream_byte = 8'h00;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		gen_depth = 0;
		bytes_sent = 0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver stalls often
		send_idle_pct = 26;
		recv_stall_pct = 46;
		directed_records();
		random_records(500);

		// the other way round
		send_idle_pct = 46;
		recv_stall_pct = 26;
		random_records(500);

		// full rate on both sides, then the terminal state
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_records(450);
		halting_tail();
		in_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (sb.errors == 0)
			$display("[typed_field_stream_decoder] OK");
		else
			$display("[typed_field_stream_decoder] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/tfsd_pkg.sv
src/tfsd_core.sv
src/typed_field_stream_decoder.sv
bench/tb_typed_field_stream_decoder.sv
